### rtl/sorted_priority_queue_top_defines.svh
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

### rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int ITEM_VALUE_W = 32;
    localparam int ITEM_PRIO_W  = 8;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic signed [ITEM_VALUE_W-1:0] item_value;
        logic [ITEM_PRIO_W-1:0]         item_priority;
    } req_t;

    typedef struct packed {
        logic signed [ITEM_VALUE_W-1:0] out_value;
        logic                           underflow;
        logic                           overflow;
        logic [COUNT_W-1:0]             entry_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic push;
        logic pop;
        logic peek;
        logic underflow;
        logic overflow;
        logic respond;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
    } sts_t;

endpackage

`default_nettype wire

### rtl/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    input  spq_pkg::req_t req,
    output spq_pkg::sts_t sts,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);

    req_t                           req_reg;
    logic [FW-1:0]                  fill_reg;
    logic [FW-1:0]                  fill_next;
    logic signed [ITEM_VALUE_W-1:0] value_reg [DEPTH];
    logic [PRIORITY_BITS-1:0]       prio_reg  [DEPTH];
    logic [PRIORITY_BITS-1:0]       pri;
    logic [DEPTH-1:0]               gt;
    logic [DEPTH-1:0]               prev_gt;
    logic [DEPTH-1:0]               at_fill;
    logic [DEPTH-1:0]               ins_here;
    rsp_t                           rsp_reg;
    rsp_t                           rsp_next;
    logic [FW+COUNT_W-1:0]          cnt_wide;

    if (PRIORITY_BITS >= ITEM_PRIO_W) begin : g_pri_wide
        assign pri = PRIORITY_BITS'(req_reg.item_priority);
    end
    else begin : g_pri_narrow
        assign pri = req_reg.item_priority[PRIORITY_BITS-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i]      = (FW'(i) < fill_reg) && (prio_reg[i] > pri);
            at_fill[i] = (FW'(i) == fill_reg);
        end
        prev_gt  = {gt[DEPTH-2:0], 1'b0};
        ins_here = (gt | at_fill) & ~prev_gt;
    end

    always_comb
    begin
        priority if (cmd.push)
            fill_next = fill_reg + FW'(1);
        else if (cmd.pop)
            fill_next = fill_reg - FW'(1);
        else
            fill_next = fill_reg;
    end

    assign sts.op    = req_reg.op;
    assign sts.empty = (fill_reg == '0);
    assign sts.full  = (fill_reg == FW'(DEPTH));

    assign cnt_wide = (FW + COUNT_W)'(fill_next);

    always_comb
    begin
        rsp_next.out_value   = (cmd.pop || cmd.peek) ? value_reg[0] : '0;
        rsp_next.underflow   = cmd.underflow;
        rsp_next.overflow    = cmd.overflow;
        rsp_next.entry_count = cnt_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.respond)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.push)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (prev_gt[i])
                begin
                    value_reg[i] <= value_reg[(i > 0) ? i - 1 : 0];
                    prio_reg[i]  <= prio_reg[(i > 0) ? i - 1 : 0];
                end
                else if (ins_here[i])
                begin
                    value_reg[i] <= req_reg.item_value;
                    prio_reg[i]  <= pri;
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                value_reg[i] <= value_reg[i+1];
                prio_reg[i]  <= prio_reg[i+1];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

### rtl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);
    import spq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = req_valid && !req_stall;
        if (state_reg == ST_EXEC)
        begin
            cmd.respond = 1'b1;
            unique case (sts.op)
                OP_PUSH:
                begin
                    cmd.overflow = sts.full;
                    cmd.push     = !sts.full;
                end
                OP_POP:
                begin
                    cmd.underflow = sts.empty;
                    cmd.pop       = !sts.empty;
                end
                OP_PEEK:
                begin
                    cmd.underflow = sts.empty;
                    cmd.peek      = !sts.empty;
                end
                OP_NONE:
                begin
                    cmd.respond = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = cmd.capture ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
        endcase
        priority if (cmd.respond)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sorted_priority_queue_top.sv
// Bounded priority queue held as a sorted row of DEPTH register entries. Each request
// (push, pop or peek) is captured, then executed in a state where every entry compares
// its priority with the new one in parallel and shifts, inserts or moves up in a single
// step; a new request is taken once the last one has executed, while the result register
// is free or being emptied. One response comes back for each request, holding the head
// value for pop and peek, the underflow and overflow flags and the entry count after the
// operation. Entries need no clearing after reset; only the fill count is reset.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

    `SPQ_ASSERT_IMPL(a_push_not_full, cmd.push, !sts.full)
    `SPQ_ASSERT_IMPL(a_pop_not_empty, cmd.pop, !sts.empty)
    `SPQ_ASSERT_NEXT(a_accept_then_respond, req_valid && !req_stall, cmd.respond)
    `SPQ_ASSERT_NEXT(a_respond_then_valid, cmd.respond, rsp_valid && !(rsp.underflow && rsp.overflow))

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int RANDOM_ITEMS  = 600;
    localparam int IDLE_LIMIT    = 2000;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    logic signed [ITEM_VALUE_W-1:0] shadow_value [DEPTH];
    logic [ITEM_PRIO_W-1:0]         shadow_prio  [DEPTH];
    int                             shadow_fill;

    rsp_t results_due [$];
    int   failures;
    int   idle_cycles;
    int   burst_left;
    int   stall_mode;
    int   stall_mode_left;

    sorted_priority_queue_top #(
        .DEPTH        (DEPTH),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic rsp_t apply_to_shadow_queue(req_t r);
        rsp_t                   res;
        int                     pos;
        int                     i;
        logic [ITEM_PRIO_W-1:0] prio;
        begin
            res  = '0;
            prio = r.item_priority & ITEM_PRIO_W'((1 << PRIORITY_BITS) - 1);
            case (r.op)
                OP_PUSH:
                begin
                    if (shadow_fill >= DEPTH)
                    begin
                        res.overflow = 1'b1;
                    end
                    else
                    begin
                        pos = shadow_fill;
                        for (i = 0; i < shadow_fill; i++)
                        begin
                            if (shadow_prio[i] > prio)
                            begin
                                pos = i;
                                break;
                            end
                        end
                        for (i = shadow_fill; i > pos; i--)
                        begin
                            shadow_value[i] = shadow_value[i-1];
                            shadow_prio[i]  = shadow_prio[i-1];
                        end
                        shadow_value[pos] = r.item_value;
                        shadow_prio[pos]  = prio;
                        shadow_fill++;
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (shadow_fill == 0)
                    begin
                        res.underflow = 1'b1;
                    end
                    else
                    begin
                        res.out_value = shadow_value[0];
                        if (r.op == OP_POP)
                        begin
                            for (i = 1; i < shadow_fill; i++)
                            begin
                                shadow_value[i-1] = shadow_value[i];
                                shadow_prio[i-1]  = shadow_prio[i];
                            end
                            shadow_fill--;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.entry_count = shadow_fill[COUNT_W-1:0];
            return res;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t due;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                results_due.push_back(apply_to_shadow_queue(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected response: out_value %0d", rsp.out_value);
                    failures++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (rsp.out_value !== due.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d", due.out_value,
                               rsp.out_value);
                        failures++;
                    end
                    if (rsp.underflow !== due.underflow)
                    begin
                        $error("underflow: expected %0b, got %0b", due.underflow,
                               rsp.underflow);
                        failures++;
                    end
                    if (rsp.overflow !== due.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", due.overflow,
                               rsp.overflow);
                        failures++;
                    end
                    if (rsp.entry_count !== due.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", due.entry_count,
                               rsp.entry_count);
                        failures++;
                    end
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 80);
        end
        else
        begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 25);
            2: rsp_stall <= ($urandom_range(0, 99) < 65);
            default: rsp_stall <= ~rsp_stall;
        endcase
    end

    task automatic send_request(input op_t op, input logic signed [ITEM_VALUE_W-1:0] value,
                                input logic [ITEM_PRIO_W-1:0] prio);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            req_valid          <= 1'b1;
            req.op             <= op;
            req.item_value     <= value;
            req.item_priority  <= prio;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            @(negedge clk);
            burst_left--;
        end
    endtask

    task automatic test_empty_queue();
        begin
            send_request(OP_POP, 32'sd0, 8'd0);
            send_request(OP_PEEK, 32'sd0, 8'd0);
            send_request(OP_NONE, 32'sd0, 8'd0);
        end
    endtask

    task automatic test_fill_and_overflow();
        int i;
        begin
            send_request(OP_PUSH, 32'sh7FFF_FFFF, 8'd255);
            send_request(OP_PUSH, 32'sh8000_0000, 8'd0);
            send_request(OP_PUSH, 32'sd1, 8'd128);
            send_request(OP_PUSH, 32'sd2, 8'd128);
            send_request(OP_PUSH, -32'sd1, 8'd0);
            send_request(OP_PUSH, 32'sd3, 8'd128);
            for (i = 0; i < 10; i++)
                send_request(OP_PUSH, $urandom, 8'($urandom_range(0, 255)));
            send_request(OP_PUSH, 32'sh5555_AAAA, 8'd0);
            send_request(OP_PEEK, 32'sd0, 8'd0);
            send_request(OP_NONE, $urandom, 8'd255);
        end
    endtask

    task automatic test_random_mix();
        int                     n;
        int                     roll;
        int                     push_share;
        op_t                    op;
        logic [ITEM_PRIO_W-1:0] prio;
        begin
            push_share = 25;
            for (n = 0; n < RANDOM_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    push_share = (push_share > 50) ? $urandom_range(15, 35)
                                                   : $urandom_range(65, 85);
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_NONE;
                else if (roll < 13)
                    op = OP_PEEK;
                else if ($urandom_range(0, 99) < push_share)
                    op = OP_PUSH;
                else
                    op = OP_POP;
                prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
                send_request(op, $urandom, prio);
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_stall       = 1'b0;
        shadow_fill     = 0;
        failures        = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        stall_mode      = 0;
        stall_mode_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_random_mix();

        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_top.sv
tb/tb.sv
